>>> rtl/csfnv_pkg.sv
`default_nettype none

package csfnv_pkg;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
    localparam logic [31:0] F32_QNAN   = 32'h7FC0_0000;
    localparam logic [63:0] F64_QNAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [30:0] F32_INF    = 31'h7F80_0000;
    localparam logic [62:0] F64_INF    = 63'h7FF0_0000_0000_0000;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CNT_W      = 4;   // holds up to 8 bytes

    typedef enum logic [2:0] {
        REQ_START    = 3'd0,
        REQ_BODY_ID  = 3'd1,
        REQ_POSITION = 3'd2,
        REQ_ROTATION = 3'd3,
        REQ_LIN_VEL  = 3'd4,
        REQ_ANG_VEL  = 3'd5,
        REQ_TRAILER  = 3'd6,
        REQ_FINISH   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        CFG_LIN_EPS  = 2'd0,
        CFG_ANG_EPS  = 2'd1,
        CFG_INCL_VEL = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FLAG
    } t_state;

    // one command per cycle to the fold unit
    typedef struct packed {
        logic       load_basis;
        logic       xor_flag;
        logic       flag_val;
        logic       step;
        logic [7:0] fold_byte;
    } t_fold_ctl;

    function automatic logic [31:0] canon_f32(input logic [31:0] b);
        logic [31:0] r;
        r = b;
        if (b[30:0] > F32_INF) begin
            r = F32_QNAN;
        end else if (b[30:0] == '0) begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [63:0] canon_f64(input logic [63:0] b);
        logic [63:0] r;
        r = b;
        if (b[62:0] > F64_INF) begin
            r = F64_QNAN;
        end else if (b[62:0] == '0) begin
            r = '0;
        end
        return r;
    endfunction

    // dead-band: small magnitudes snap to +0, then canonicalize
    function automatic logic [31:0] quant_vel(input logic [31:0] v, input logic [30:0] eps);
        logic [31:0] r;
        r = v;
        if (v[30:0] <= F32_INF && eps <= F32_INF && v[30:0] < eps) begin
            r = '0;
        end
        return canon_f32(r);
    endfunction

endpackage

`default_nettype wire

>>> rtl/csfnv_fold.sv
`default_nettype none

// Running hash register with the shared xor/multiply-by-prime step.
module csfnv_fold (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire csfnv_pkg::t_fold_ctl  i_ctl,
    output logic [63:0]                o_hash
);

    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic [63:0] mix;

    // FNV prime is 2^40 + 0x1B3: shift-add, low 64 bits kept
    assign mix = r_hash ^ {56'd0, i_ctl.fold_byte};

    always_comb begin
        n_hash = r_hash;
        if (i_ctl.load_basis) begin
            n_hash = csfnv_pkg::FNV_OFFSET;
        end else if (i_ctl.xor_flag) begin
            n_hash = r_hash ^ {63'd0, i_ctl.flag_val};
        end else if (i_ctl.step) begin
            n_hash = mix + (mix << 1) + (mix << 4) + (mix << 5)
                   + (mix << 7) + (mix << 8) + (mix << 40);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= csfnv_pkg::FNV_OFFSET;
        end else begin
            r_hash <= n_hash;
        end
    end

    assign o_hash = r_hash;

endmodule

`default_nettype wire

>>> rtl/csfnv_ctrl.sv
`default_nettype none

// Sequencer: decodes a request into a byte queue and feeds the fold unit
// one byte per cycle.
module csfnv_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [2:0]            i_req_type,
    input  wire logic [63:0]           i_word,
    input  wire logic [7:0]            i_motion_kind,
    input  wire logic                  i_is_awake,
    input  wire logic [30:0]           i_lin_eps,
    input  wire logic [30:0]           i_ang_eps,
    input  wire logic                  i_incl_vel,
    output logic                       o_busy,
    output csfnv_pkg::t_fold_ctl       o_fold_ctl
);

    csfnv_pkg::t_state r_state, n_state;
    logic [63:0]                  r_data, n_data;
    logic [63:0]                  r_word, n_word;
    logic [csfnv_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                         r_start, n_start;
    logic                         r_rneg, n_rneg;
    logic [1:0]                   r_rpos, n_rpos;

    logic [31:0] lo;
    logic        w_neg;
    logic        neg_sel;

    assign lo    = i_word[31:0];
    // w below zero: sign set, nonzero, not NaN
    assign w_neg = lo[31] && (lo[30:0] != '0) && (lo[30:0] <= csfnv_pkg::F32_INF);
    assign neg_sel = (r_rpos == 2'd0) ? w_neg : r_rneg;

    always_comb begin
        n_state    = r_state;
        n_data     = r_data;
        n_word     = r_word;
        n_cnt      = r_cnt;
        n_start    = r_start;
        n_rneg     = r_rneg;
        n_rpos     = r_rpos;
        o_fold_ctl = '0;

        case (r_state)
            csfnv_pkg::ST_IDLE: begin
                if (i_accept) begin
                    case (csfnv_pkg::t_req'(i_req_type))
                        csfnv_pkg::REQ_START: begin
                            o_fold_ctl.load_basis = 1'b1;
                            n_data  = {csfnv_pkg::canon_f32({1'b0, i_ang_eps}),
                                       csfnv_pkg::canon_f32({1'b0, i_lin_eps})};
                            n_cnt   = 4'd8;
                            n_word  = i_word;
                            n_start = 1'b1;
                            n_rpos  = 2'd0;
                            n_rneg  = 1'b0;
                            n_state = csfnv_pkg::ST_FOLD;
                        end
                        csfnv_pkg::REQ_BODY_ID: begin
                            n_data  = {32'd0, lo};
                            n_cnt   = 4'd4;
                            n_rpos  = 2'd0;
                            n_state = csfnv_pkg::ST_FOLD;
                        end
                        csfnv_pkg::REQ_POSITION: begin
                            n_data  = csfnv_pkg::canon_f64(i_word);
                            n_cnt   = 4'd8;
                            n_state = csfnv_pkg::ST_FOLD;
                        end
                        csfnv_pkg::REQ_ROTATION: begin
                            n_rneg  = neg_sel;
                            n_data  = {32'd0, csfnv_pkg::canon_f32(lo ^ {neg_sel, 31'd0})};
                            n_cnt   = 4'd4;
                            n_rpos  = r_rpos + 2'd1;
                            n_state = csfnv_pkg::ST_FOLD;
                        end
                        csfnv_pkg::REQ_LIN_VEL: begin
                            if (i_incl_vel) begin
                                n_data  = {32'd0, csfnv_pkg::quant_vel(lo, i_lin_eps)};
                                n_cnt   = 4'd4;
                                n_state = csfnv_pkg::ST_FOLD;
                            end
                        end
                        csfnv_pkg::REQ_ANG_VEL: begin
                            if (i_incl_vel) begin
                                n_data  = {32'd0, csfnv_pkg::quant_vel(lo, i_ang_eps)};
                                n_cnt   = 4'd4;
                                n_state = csfnv_pkg::ST_FOLD;
                            end
                        end
                        csfnv_pkg::REQ_TRAILER: begin
                            n_data  = {48'd0, 7'd0, i_is_awake, i_motion_kind};
                            n_cnt   = 4'd2;
                            n_state = csfnv_pkg::ST_FOLD;
                        end
                        default: begin
                            // finish: result taken straight from the hash
                        end
                    endcase
                end
            end
            csfnv_pkg::ST_FOLD: begin
                o_fold_ctl.step      = 1'b1;
                o_fold_ctl.fold_byte = r_data[7:0];
                n_data = r_data >> 8;
                n_cnt  = r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    n_state = r_start ? csfnv_pkg::ST_FLAG : csfnv_pkg::ST_IDLE;
                end
            end
            csfnv_pkg::ST_FLAG: begin
                o_fold_ctl.xor_flag = 1'b1;
                o_fold_ctl.flag_val = i_incl_vel;
                n_data  = r_word;
                n_cnt   = 4'd8;
                n_start = 1'b0;
                n_state = csfnv_pkg::ST_FOLD;
            end
            default: begin
                n_state = csfnv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csfnv_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_start <= 1'b0;
            r_rneg  <= 1'b0;
            r_rpos  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_start <= n_start;
            r_rneg  <= n_rneg;
            r_rpos  <= n_rpos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_word <= n_word;
    end

    assign o_busy = (r_state != csfnv_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/canonical_state_fnv1a64_hasher_unit.sv
`default_nettype none

// Canonical rigid-body state hasher, FNV-1a 64 bit.
// Input channel: i_in_valid / o_in_stall with i_req_type, i_word,
//   i_motion_kind, i_is_awake. A request is taken when valid is high and
//   stall is low.
// Output channel: o_out_valid / i_out_stall with o_hash_value; one result
//   per finish request, nothing for the other types.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//   0 linear eps, 1 angular eps, 2 include velocities; index 3 is dropped.
//   Write only while the block is idle.
// Folding: a request is taken, then its bytes go one byte per cycle
//   through the shared xor/multiply-by-prime unit while the input stalls:
//   body id, rotation and velocity 4 bytes, position 8, trailer 2, start
//   8 epsilon bytes, a flag xor, then 8 count bytes. Disabled velocity and
//   finish requests fold nothing. The hash lands in the output register
//   in the cycle after a finish is accepted.
// Stall: the result register holds while i_out_stall is high; other
//   requests keep flowing, only a second finish waits for the slot.
// Reset (sync, active low): hash = offset basis, rotation state cleared,
//   config = 0 / 0 / 1, output empty.
module canonical_state_fnv1a64_hasher_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_req_type,
    input  wire logic [63:0]                       i_word,
    input  wire logic [7:0]                        i_motion_kind,
    input  wire logic                              i_is_awake,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [63:0]                            o_hash_value,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [csfnv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [csfnv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [30:0] r_lin_eps;
    logic [30:0] r_ang_eps;
    logic        r_incl_vel;

    logic        r_out_valid;
    logic [63:0] r_out_hash;

    logic        busy;
    logic        in_acc;
    logic        is_finish;
    logic        fin_acc;
    logic        out_full;
    logic [63:0] hash;
    csfnv_pkg::t_fold_ctl fold_ctl;

    assign o_cfg_ready = 1'b1;

    // a finish needs the result slot free (or draining this cycle)
    assign is_finish  = (i_req_type == csfnv_pkg::REQ_FINISH);
    assign out_full   = r_out_valid && i_out_stall;
    assign o_in_stall = busy || (is_finish && out_full);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign fin_acc    = in_acc && is_finish;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_eps  <= '0;
            r_ang_eps  <= '0;
            r_incl_vel <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (csfnv_pkg::t_cfg_idx'(i_cfg_index))
                csfnv_pkg::CFG_LIN_EPS:  r_lin_eps  <= i_cfg_data[30:0];
                csfnv_pkg::CFG_ANG_EPS:  r_ang_eps  <= i_cfg_data[30:0];
                csfnv_pkg::CFG_INCL_VEL: r_incl_vel <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    csfnv_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_req_type    (i_req_type),
        .i_word        (i_word),
        .i_motion_kind (i_motion_kind),
        .i_is_awake    (i_is_awake),
        .i_lin_eps     (r_lin_eps),
        .i_ang_eps     (r_ang_eps),
        .i_incl_vel    (r_incl_vel),
        .o_busy        (busy),
        .o_fold_ctl    (fold_ctl)
    );

    csfnv_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fold_ctl),
        .o_hash  (hash)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_acc) begin
            r_out_hash <= hash;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

    // finish request shows up as a result next cycle
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_acc |=> o_out_valid)
        else $error("finish request produced no result");

    // a body id request keeps the input blocked while its bytes are folded
    a_body_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == csfnv_pkg::REQ_BODY_ID) |=> o_in_stall)
        else $error("input not blocked during fold");

    // hash only moves while the sequencer is folding or on a start
    a_hash_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !(in_acc && i_req_type == csfnv_pkg::REQ_START)) |=> $stable(hash))
        else $error("hash changed while idle");

    // after reset the block is empty and accepting
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !busy))
        else $error("bad state after reset");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam logic [csfnv_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index the block drops
    localparam int unsigned SETTLE_CYCLES = 24;     // outlasts the longest request, a start
    localparam int unsigned HOLD_CYCLES   = 400;    // long result back-pressure
    localparam int unsigned PHASE_ITEMS   = 500;    // counted requests per phase, disabled velocities apart

    // clock / reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // request side
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    csfnv_pkg::t_req       req_type    = csfnv_pkg::REQ_START;
    logic [63:0]           req_word    = '0;
    logic [7:0]            motion_kind = '0;
    logic                  is_awake    = 1'b0;

    // result side
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [63:0]           hash_out;

    // register writes
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [csfnv_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [csfnv_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    canonical_state_fnv1a64_hasher_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_word        (req_word),
        .i_motion_kind (motion_kind),
        .i_is_awake    (is_awake),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hash_value  (hash_out),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Hash model: mirrors the block's state and register file
    // ------------------------------------------------------------------
    logic [63:0] model_hash   = csfnv_pkg::FNV_OFFSET;
    logic        model_negate = 1'b0;       // rotation set is being flipped
    logic [1:0]  model_slot   = '0;         // next rotation component, 0 = w
    logic [30:0] lin_thresh   = '0;
    logic [30:0] ang_thresh   = '0;
    logic        vel_on       = 1'b1;

    logic [63:0] pending_hashes[$];         // one per accepted finish
    logic [63:0] want_hash;
    int unsigned folded_items = 0;          // accepted requests, disabled velocities apart
    int unsigned bad_results  = 0;

    bit burst_mode   = 1'b0;                // no sender gaps
    bit hold_pending = 1'b0;                // ask the result side for a long hold
    bit hold_active  = 1'b0;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] v,
                                             input int unsigned nbytes);
        int unsigned i;
        for (i = 0; i < nbytes; i++) begin
            h = (h ^ {56'd0, v[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic bit single_nan(input logic [30:0] mag);
        return mag[30:23] == 8'hFF && mag[22:0] != '0;
    endfunction

    function automatic logic [31:0] tidy_single(input logic [31:0] b);
        if (single_nan(b[30:0])) return csfnv_pkg::F32_QNAN;
        if (b[30:0] == '0) return '0;
        return b;
    endfunction

    // Advance the model by one accepted request.
    task automatic fold_request(input csfnv_pkg::t_req kind, input logic [63:0] w,
                                input logic [7:0] mk, input logic aw);
        logic [31:0] lo;
        logic [30:0] thresh;
        bit          skipped;
        lo      = w[31:0];
        skipped = 1'b0;
        case (kind)
            csfnv_pkg::REQ_START: begin
                model_hash = fnv_fold(csfnv_pkg::FNV_OFFSET,
                                      {32'd0, tidy_single({1'b0, lin_thresh})}, 4);
                model_hash = fnv_fold(model_hash, {32'd0, tidy_single({1'b0, ang_thresh})}, 4);
                model_hash = model_hash ^ {63'd0, vel_on};
                model_hash = fnv_fold(model_hash, w, 8);
                model_slot   = '0;
                model_negate = 1'b0;
            end
            csfnv_pkg::REQ_BODY_ID: begin
                model_hash = fnv_fold(model_hash, {32'd0, lo}, 4);
                model_slot = '0;
            end
            csfnv_pkg::REQ_POSITION: begin
                // NaN -> quiet NaN, -0 -> +0
                if (w[62:52] == 11'h7FF && w[51:0] != '0) begin
                    model_hash = fnv_fold(model_hash, csfnv_pkg::F64_QNAN, 8);
                end else if (w[62:0] == '0) begin
                    model_hash = fnv_fold(model_hash, 64'd0, 8);
                end else begin
                    model_hash = fnv_fold(model_hash, w, 8);
                end
            end
            csfnv_pkg::REQ_ROTATION: begin
                // w decides whether the whole set gets negated
                if (model_slot == '0) begin
                    model_negate = lo[31] && lo[30:0] != '0 && !single_nan(lo[30:0]);
                end
                if (model_negate) begin
                    lo[31] = ~lo[31];
                end
                model_hash = fnv_fold(model_hash, {32'd0, tidy_single(lo)}, 4);
                model_slot = model_slot + 2'd1;
            end
            csfnv_pkg::REQ_LIN_VEL, csfnv_pkg::REQ_ANG_VEL: begin
                if (vel_on) begin
                    thresh = (kind == csfnv_pkg::REQ_LIN_VEL) ? lin_thresh : ang_thresh;
                    // dead band; a NaN on either side never counts as small
                    if (!single_nan(lo[30:0]) && !single_nan(thresh) && lo[30:0] < thresh) begin
                        lo = '0;
                    end
                    model_hash = fnv_fold(model_hash, {32'd0, tidy_single(lo)}, 4);
                end else begin
                    skipped = 1'b1;
                end
            end
            csfnv_pkg::REQ_TRAILER: begin
                model_hash = fnv_fold(model_hash, {56'd0, mk}, 1);
                model_hash = fnv_fold(model_hash, {63'd0, aw}, 1);
            end
            csfnv_pkg::REQ_FINISH: begin
                pending_hashes.push_back(model_hash);
            end
            default: begin
            end
        endcase
        if (!skipped) begin
            folded_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Random sources
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_single();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 15))
            0: b[30:0] = '0;                       // signed zero
            1: b[30:0] = csfnv_pkg::F32_INF;       // infinity
            2: begin                               // NaN, any payload
                b[30:23] = 8'hFF;
                if (b[22:0] == '0) b[22] = 1'b1;
            end
            3: b[30:23] = '0;                      // subnormal
            4: ;                                   // raw bits
            default: b[30:23] = 8'($urandom_range(100, 154));
        endcase
        return b;
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        b = rand64();
        case ($urandom_range(0, 15))
            0: b[62:0] = '0;
            1: b[62:0] = csfnv_pkg::F64_INF;
            2: begin
                b[62:52] = 11'h7FF;
                if (b[51:0] == '0) b[51] = 1'b1;
            end
            3: b[62:52] = '0;
            4: ;
            default: b[62:52] = 11'($urandom_range(900, 1150));
        endcase
        return b;
    endfunction

    // a quarter of the velocities sit at the threshold or one step either side
    function automatic logic [31:0] rand_velocity(input logic [30:0] thresh);
        logic [31:0] v;
        logic [30:0] nudge;
        v = rand_single();
        if ($urandom_range(0, 3) == 0) begin
            nudge   = 31'($urandom_range(0, 2));
            v[30:0] = thresh + nudge - 31'd1;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, with an on-demand long hold
    // ------------------------------------------------------------------
    initial begin : result_stall
        int unsigned span;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_active  = 1'b1;
                out_stall   <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_active  = 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                // quiet stretch, results drain freely
                span       = $urandom_range(100, 300);
                out_stall <= 1'b0;
                repeat (span - 1) @(posedge clk);
            end else begin
                span       = idle_len() + 1;
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (span - 1) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every taken result pops the oldest expected hash
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: hash_value expected no result actual %h", $time, hash_out);
                bad_results++;
            end else begin
                want_hash = pending_hashes.pop_front();
                if (hash_out !== want_hash) begin
                    $display("%0t: hash_value expected %h actual %h",
                             $time, want_hash, hash_out);
                    bad_results++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------

    // Valid stays high after the handshake; the next call either keeps it
    // up (no gap) or drops it for the gap.
    task automatic send_request(input csfnv_pkg::t_req kind, input logic [63:0] w,
                                input logic [7:0] mk, input logic aw);
        int unsigned idle;
        idle = burst_mode ? 0 : idle_len();
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        req_word    <= w;
        motion_kind <= mk;
        is_awake    <= aw;
        do @(posedge clk); while (in_stall !== 1'b0);
        fold_request(kind, w, mk, aw);
    endtask

    task automatic send_plain(input csfnv_pkg::t_req kind, input logic [63:0] w);
        send_request(kind, w, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [csfnv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [csfnv_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            csfnv_pkg::CFG_LIN_EPS:  lin_thresh = data[30:0];
            csfnv_pkg::CFG_ANG_EPS:  ang_thresh = data[30:0];
            csfnv_pkg::CFG_INCL_VEL: vel_on     = data[0];
            default: ;
        endcase
    endtask

    // Block is idle once every hash is out and the longest request has had
    // time to finish.
    task automatic await_idle();
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // start, bodies, finish; a broken frame loses or repeats pieces
    task automatic send_frame(input int unsigned bodies, input bit broken);
        int unsigned b, k, turns, drop;
        logic [63:0] count;
        drop  = broken ? 15 : 0;
        count = ($urandom_range(0, 9) == 0) ? rand64() : {32'd0, bodies};
        if (!broken || $urandom_range(0, 3) != 0) send_plain(csfnv_pkg::REQ_START, count);
        for (b = 0; b < bodies; b++) begin
            turns = broken ? $urandom_range(3, 6) : 4;
            if ($urandom_range(0, 99) >= drop) send_plain(csfnv_pkg::REQ_BODY_ID, rand64());
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(0, 99) >= drop) begin
                    send_plain(csfnv_pkg::REQ_POSITION, rand_double());
                end
            end
            for (k = 0; k < turns; k++) begin
                if ($urandom_range(0, 99) >= drop) begin
                    send_plain(csfnv_pkg::REQ_ROTATION, {$urandom, rand_single()});
                end
            end
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(0, 99) >= drop) begin
                    send_plain(csfnv_pkg::REQ_LIN_VEL, {$urandom, rand_velocity(lin_thresh)});
                end
            end
            for (k = 0; k < 3; k++) begin
                if ($urandom_range(0, 99) >= drop) begin
                    send_plain(csfnv_pkg::REQ_ANG_VEL, {$urandom, rand_velocity(ang_thresh)});
                end
            end
            if ($urandom_range(0, 99) >= drop) send_plain(csfnv_pkg::REQ_TRAILER, rand64());
        end
        send_plain(csfnv_pkg::REQ_FINISH, rand64());
        if (broken && $urandom_range(0, 2) == 0) send_plain(csfnv_pkg::REQ_FINISH, rand64());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers: field extremes and float corner cases.
    task automatic test_fields_and_specials();
        send_request(csfnv_pkg::REQ_FINISH,   '1, 8'hFF, 1'b1);  // hash after reset
        send_request(csfnv_pkg::REQ_START,    '1, 8'h00, 1'b0);  // largest body count
        send_request(csfnv_pkg::REQ_BODY_ID,  64'hFFFF_FFFF_0000_0000, 8'hA5, 1'b1);  // upper half
        send_request(csfnv_pkg::REQ_POSITION, 64'h8000_0000_0000_0000, 8'h00, 1'b0);  // -0.0
        send_request(csfnv_pkg::REQ_POSITION, 64'hFFF0_0000_0000_0001, 8'h00, 1'b0);  // NaN, sign
        send_request(csfnv_pkg::REQ_POSITION, 64'h7FF0_0000_0000_0000, 8'h00, 1'b0);  // +inf kept
        send_request(csfnv_pkg::REQ_ROTATION, 64'h0000_0000_BF80_0000, 8'h00, 1'b0);  // w < 0
        send_request(csfnv_pkg::REQ_ROTATION, 64'hFFFF_FFFF_8000_0000, 8'h00, 1'b0);  // flipped -0
        send_request(csfnv_pkg::REQ_ROTATION, 64'h0000_0000_FFC0_0001, 8'h00, 1'b0);  // NaN
        send_request(csfnv_pkg::REQ_ROTATION, 64'h0000_0000_3F00_0000, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_ROTATION, 64'h0000_0000_FFC0_0000, 8'h00, 1'b0);  // new w
        send_request(csfnv_pkg::REQ_LIN_VEL,  64'h0000_0000_0000_0001, 8'h00, 1'b0);  // zero eps
        send_request(csfnv_pkg::REQ_ANG_VEL,  64'h0000_0000_8000_0000, 8'h00, 1'b0);  // -0 to +0
        send_request(csfnv_pkg::REQ_TRAILER,  '0, 8'hFF, 1'b1);
        send_request(csfnv_pkg::REQ_TRAILER,  '1, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_FINISH,   '0, 8'h00, 1'b0);
    endtask

    // Dead band at and around a threshold; NaN threshold passes everything.
    task automatic test_thresholds();
        await_idle();
        write_reg(csfnv_pkg::CFG_LIN_EPS,  32'h3F80_0000);   // 1.0
        write_reg(csfnv_pkg::CFG_ANG_EPS,  32'hFFFF_FFFF);   // NaN pattern, top bit dropped
        write_reg(csfnv_pkg::CFG_INCL_VEL, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED,              32'hFFFF_FFFF);   // dropped by the block
        cfg_valid <= 1'b0;
        send_request(csfnv_pkg::REQ_START,   '0, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_LIN_VEL, 64'h0000_0000_BF7F_FFFF, 8'h00, 1'b0);  // to +0
        send_request(csfnv_pkg::REQ_LIN_VEL, 64'h0000_0000_3F80_0000, 8'h00, 1'b0);  // equal
        send_request(csfnv_pkg::REQ_LIN_VEL, 64'h0000_0000_FF80_0001, 8'h00, 1'b0);  // NaN vel
        send_request(csfnv_pkg::REQ_ANG_VEL, 64'h0000_0000_0000_0001, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_FINISH,  '0, 8'h00, 1'b0);
    endtask

    // Velocities ignored; start still folds flag and thresholds.
    task automatic test_velocities_off();
        await_idle();
        write_reg(csfnv_pkg::CFG_INCL_VEL, 32'h0000_0000);
        write_reg(csfnv_pkg::CFG_LIN_EPS,  32'h7F80_0000);
        write_reg(csfnv_pkg::CFG_ANG_EPS,  32'h0000_0000);
        cfg_valid <= 1'b0;
        send_request(csfnv_pkg::REQ_LIN_VEL, 64'h0000_0000_1234_5678, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_ANG_VEL, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_START,   64'h0000_0000_0000_0002, 8'h00, 1'b0);
        send_request(csfnv_pkg::REQ_FINISH,  '0, 8'h00, 1'b0);
    endtask

    // One register setting, then mostly frames with random content plus noise.
    task automatic random_phase(input logic [31:0] lin, input logic [31:0] ang,
                                input logic [31:0] vel);
        int unsigned target, bodies;
        logic [2:0]  code;
        await_idle();
        write_reg(csfnv_pkg::CFG_LIN_EPS,  lin);
        write_reg(csfnv_pkg::CFG_ANG_EPS,  ang);
        write_reg(csfnv_pkg::CFG_INCL_VEL, vel);
        cfg_valid <= 1'b0;
        target = folded_items + PHASE_ITEMS;
        while (folded_items < target) begin
            if ($urandom_range(0, 3) != 0) begin
                bodies     = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8)
                                                         : $urandom_range(0, 3);
                burst_mode = ($urandom_range(0, 4) == 0);
                send_frame(bodies, $urandom_range(0, 3) == 0);
                burst_mode = 1'b0;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    code = 3'($urandom_range(0, 7));
                    send_plain(csfnv_pkg::t_req'(code), rand64());
                end
            end
        end
    endtask

    task automatic test_random_streams();
        logic [31:0] eps_a, eps_b;
        eps_a          = $urandom;
        eps_a[30:23]   = 8'($urandom_range(110, 125));
        eps_b          = $urandom;
        eps_b[30:23]   = 8'($urandom_range(100, 120));
        random_phase(32'h7F80_0000, 32'h0000_0001, 32'h0000_0001);
        random_phase(eps_a, eps_b, $urandom & 32'hFFFF_FFFE);
        random_phase({1'b1, eps_b[30:0]}, 32'h7FFF_FFFF, $urandom | 32'h0000_0001);
        random_phase(32'h3A83_126F, 32'h3C23_D70A, 32'h0000_0001);
    endtask

    // Result side holds off while finishes keep coming; the second one must
    // back up into the request channel.
    task automatic test_result_backlog();
        await_idle();
        hold_pending = 1'b1;
        while (!hold_active) @(posedge clk);
        burst_mode = 1'b1;
        repeat (3) begin
            send_frame(1, 1'b0);
            repeat (3) send_plain(csfnv_pkg::REQ_FINISH, rand64());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_fields_and_specials();
        test_thresholds();
        test_velocities_off();
        test_random_streams();
        test_result_backlog();
        await_idle();
        if (bad_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> canonical_state_fnv1a64_hasher_unit.f
rtl/csfnv_pkg.sv
rtl/csfnv_fold.sv
rtl/csfnv_ctrl.sv
rtl/canonical_state_fnv1a64_hasher_unit.sv
tb/testbench.sv
